>>> rtl/hshc_pkg.sv
// types and constants shared by the hub suspend handshake controller
`default_nettype none

package hshc_pkg;

  // event codes carried in the mode field
  typedef enum logic [3:0] {
    EV_SUSPEND   = 4'd0,
    EV_RESUME    = 4'd1,
    EV_TICK      = 4'd2,
    EV_ACK       = 4'd3,
    EV_XFER_ONE  = 4'd4,
    EV_XFER_BAT  = 4'd5,
    EV_HUB_RESET = 4'd6,
    EV_LINE_FALL = 4'd7,
    EV_XFER_DONE = 4'd8,
    EV_POLL      = 4'd9
  } event_e;

  // handshake phase
  typedef enum logic [1:0] {
    PH_ACTIVE     = 2'd0,
    PH_SUSPENDING = 2'd1,
    PH_SUSPENDED  = 2'd2,
    PH_WAKING     = 2'd3
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_MODE_ON      = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RESUME_DELAY = 1'b1;

  localparam logic [15:0] RESUME_DELAY_RESET = 16'd1000;
  localparam logic [12:0] MAX_FRAME          = 13'd4096;
  localparam logic [12:0] MARK_MIN_LEN       = 13'd10;
  localparam logic [7:0]  CMD_MARK           = 8'h80;
  localparam logic [7:0]  CMD_BODY_MASK      = 8'h7f;

  typedef struct packed {
    logic [3:0]  mode;
    logic        ack_suspended;
    logic        line_level;
    logic [7:0]  cmd_in;
    logic [12:0] frame_len;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] state_now;
    logic       suspend_refused;
    logic       hub_hold;
    logic       data_hold;
    logic       data_ready;
    logic       reader_notify;
    logic [7:0] cmd_out;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/hub_suspend_handshake_controller.sv
// hub suspend handshake controller: event register, state update, result register
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one event beat per
//   cycle while in_stall_o is low. Output channel (out_valid_o / out_stall_i /
//   out_data_o) gives one result beat for every event beat, in order.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the handshake mode enable
//   (index 0) and the resume delay in ticks (index 1); it is always ready. The
//   user must write it only while no event is in flight; the block does not enforce it.
//   An accepted beat is registered in the event register, and its result is
//   loaded into the result register once that register is empty or being read;
//   the result beat is offered from the result register.
//   Throughput: one event per cycle while out_stall_i is low, set by the single
//   update of the state registers from the event register into the result register.
//   Reset: asynchronous, active low; the phase returns to active, holds, the
//   forced read and the timer clear, the mode is off and the delay is 1000.
//   Stall: while the receiver stalls, the result holds and the event register
//   holds its beat; in_stall_o rises only when both registers are full.
`default_nettype none

module hub_suspend_handshake_controller (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire hshc_pkg::in_beat_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output hshc_pkg::out_beat_t                  out_data_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [hshc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire  [hshc_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  // configuration registers
  logic        mode_on_q;
  logic [15:0] resume_delay_q;

  // event register
  logic               ev_valid_q;
  hshc_pkg::in_beat_t ev_q;

  // handshake state
  hshc_pkg::phase_e phase_q, phase_d;
  logic        force_read_q, force_read_d;
  logic        hub_hold_q, hub_hold_d;
  logic        data_hold_q, data_hold_d;
  logic        timer_run_q, timer_run_d;
  logic [15:0] timer_cnt_q, timer_cnt_d;

  // result register
  logic                out_valid_q;
  hshc_pkg::out_beat_t out_q;
  hshc_pkg::out_beat_t res_d;

  logic ev_adv;
  logic ev_take;

  // handshake flow
  assign ev_adv      = ev_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = ev_valid_q && out_valid_q && out_stall_i;
  assign ev_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_on_q      <= 1'b0;
      resume_delay_q <= hshc_pkg::RESUME_DELAY_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hshc_pkg::REG_MODE_ON:      mode_on_q      <= cfg_wdata_i[0];
        hshc_pkg::REG_RESUME_DELAY: resume_delay_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (ev_take) begin
      ev_valid_q <= 1'b1;
    end else if (ev_adv) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take) begin
      ev_q <= in_data_i;
    end
  end

  // state update and result for the registered event
  always_comb begin
    logic       refused;
    logic       ready;
    logic       notify;
    logic [7:0] cmd;
    phase_d      = phase_q;
    force_read_d = force_read_q;
    hub_hold_d   = hub_hold_q;
    data_hold_d  = data_hold_q;
    timer_run_d  = timer_run_q;
    timer_cnt_d  = timer_cnt_q;
    refused      = 1'b0;
    ready        = 1'b0;
    notify       = 1'b0;
    cmd          = 8'd0;

    case (ev_q.mode)
      hshc_pkg::EV_SUSPEND: begin
        if (mode_on_q) begin
          timer_run_d = 1'b0;
          if (phase_q == hshc_pkg::PH_ACTIVE) begin
            hub_hold_d   = 1'b1;
            phase_d      = hshc_pkg::PH_SUSPENDING;
            force_read_d = 1'b1;
            notify       = 1'b1;
            refused      = 1'b1;
          end
        end
      end
      hshc_pkg::EV_RESUME: begin
        if (mode_on_q && phase_q == hshc_pkg::PH_SUSPENDED) begin
          timer_run_d = 1'b1;
          timer_cnt_d = resume_delay_q;
        end
      end
      hshc_pkg::EV_TICK: begin
        if (timer_run_q) begin
          if (timer_cnt_q <= 16'd1) begin
            timer_cnt_d = 16'd0;
            timer_run_d = 1'b0;
            if (phase_q == hshc_pkg::PH_SUSPENDED) begin
              hub_hold_d   = 1'b1;
              phase_d      = hshc_pkg::PH_WAKING;
              force_read_d = 1'b1;
              notify       = 1'b1;
            end
          end else begin
            timer_cnt_d = timer_cnt_q - 16'd1;
          end
        end
      end
      hshc_pkg::EV_ACK: begin
        if (phase_q == hshc_pkg::PH_SUSPENDING && ev_q.ack_suspended) begin
          phase_d     = hshc_pkg::PH_SUSPENDED;
          timer_run_d = 1'b1;
          timer_cnt_d = resume_delay_q;
          hub_hold_d  = 1'b0;
        end else if (phase_q == hshc_pkg::PH_WAKING && !ev_q.ack_suspended) begin
          phase_d    = hshc_pkg::PH_ACTIVE;
          hub_hold_d = 1'b0;
        end
      end
      hshc_pkg::EV_XFER_ONE: begin
        if (phase_q == hshc_pkg::PH_SUSPENDED) begin
          hub_hold_d   = 1'b1;
          timer_run_d  = 1'b0;
          phase_d      = hshc_pkg::PH_WAKING;
          force_read_d = 1'b1;
        end
      end
      hshc_pkg::EV_HUB_RESET: begin
        phase_d    = hshc_pkg::PH_ACTIVE;
        hub_hold_d = 1'b0;
      end
      hshc_pkg::EV_LINE_FALL: begin
        if (phase_q == hshc_pkg::PH_SUSPENDED) begin
          data_hold_d = 1'b1;
        end
        notify = 1'b1;
      end
      hshc_pkg::EV_XFER_DONE: begin
        if (ev_q.line_level) begin
          data_hold_d = 1'b0;
        end
      end
      hshc_pkg::EV_POLL: begin
        if (!ev_q.line_level || force_read_q) begin
          ready        = 1'b1;
          force_read_d = 1'b0;
        end
      end
      default: ;
    endcase

    // command byte for both transfer kinds, marked from the updated phase
    if (ev_q.mode == hshc_pkg::EV_XFER_ONE || ev_q.mode == hshc_pkg::EV_XFER_BAT) begin
      if (ev_q.frame_len > hshc_pkg::MAX_FRAME) begin
        cmd = 8'd0;
      end else if (mode_on_q && ev_q.frame_len >= hshc_pkg::MARK_MIN_LEN) begin
        cmd = ev_q.cmd_in & hshc_pkg::CMD_BODY_MASK;
        if (phase_d == hshc_pkg::PH_SUSPENDING || phase_d == hshc_pkg::PH_SUSPENDED) begin
          cmd = cmd | hshc_pkg::CMD_MARK;
        end
      end else begin
        cmd = ev_q.cmd_in;
      end
    end

    res_d.state_now       = phase_d;
    res_d.suspend_refused = refused;
    res_d.hub_hold        = hub_hold_d;
    res_d.data_hold       = data_hold_d;
    res_d.data_ready      = ready;
    res_d.reader_notify   = notify;
    res_d.cmd_out         = cmd;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hshc_pkg::PH_ACTIVE;
      force_read_q <= 1'b0;
      hub_hold_q   <= 1'b0;
      data_hold_q  <= 1'b0;
      timer_run_q  <= 1'b0;
      timer_cnt_q  <= 16'd0;
    end else if (ev_adv) begin
      phase_q      <= phase_d;
      force_read_q <= force_read_d;
      hub_hold_q   <= hub_hold_d;
      data_hold_q  <= data_hold_d;
      timer_run_q  <= timer_run_d;
      timer_cnt_q  <= timer_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ev_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_adv) begin
      out_q <= res_d;
    end
  end

`ifndef NO_ASSERTIONS
  // an event that advances always reaches the result register on the next edge
  a_ev_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_adv |=> out_valid_o)
    else $error("event beat did not reach result register");

  // the shown state always matches the phase register
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.state_now == phase_q))
    else $error("result state differs from phase register");

  // a refused suspend moves to suspending with the hold set and a notify
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.suspend_refused) |->
      (out_data_o.reader_notify && out_data_o.hub_hold &&
       phase_q == hshc_pkg::PH_SUSPENDING))
    else $error("refused suspend without hold, notify or phase change");

  // input is stalled only when both registers are full and output is stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ev_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without back pressure");
`endif

endmodule

`default_nettype wire
